@@ design/obb_pkg.sv @@
// Package for the oriented-box separating-axis test block.
// Holds shared widths, the micro-op type used between sequencer and datapath.
package obb_pkg;
  localparam int unsigned COMPONENT_BITS_DEF = 16;
  localparam int unsigned BRANCH_BITS_DEF    = 10;

  // Datapath operation codes issued by the sequencer
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_CROSS = 3'd1,  // cross product term into axis register
    OP_LHS   = 3'd2,  // diff . L term into lhs accumulator
    OP_DOT   = 3'd3,  // a_i . L term into dot accumulator
    OP_RHS   = 3'd4,  // |dot| * |h_i| into rhs accumulator
    OP_CMP   = 3'd5   // compare shifted lhs against rhs into sep
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] sel_a;   // axis index 0..5
    logic [1:0] comp;    // component 0..2
    logic       first;   // first term of a sum
    logic       use_ax;  // axis is a box axis (not cross product)
    logic [2:0] ax_i;    // box axis index for face axes
  } uop_t;
endpackage

@@ design/obb_dp.sv @@
// Shared multiply-accumulate datapath for the separating-axis test.
// Depends on obb_pkg (uop_t, op_t).
module obb_dp #(
  parameter int unsigned CB = obb_pkg::COMPONENT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  obb_pkg::uop_t       uop,
  input  logic [3*CB-1:0]     ax [6],
  input  logic [3*CB-1:0]     hs [2],
  input  logic [3*CB+2:0]     diff,   // three (CB+1)-bit components
  output logic                sep
);
  localparam int unsigned LW  = 2*CB + 2;       // cross product component
  localparam int unsigned DW  = CB + 1;
  localparam int unsigned PW  = LW + DW;         // single product
  localparam int unsigned SW  = PW + 2;          // three-term sums
  localparam int unsigned AW  = SW + CB;         // rhs and shifted lhs

  logic signed [LW-1:0]  l_r [3];
  logic signed [SW-1:0]  lhs_r;
  logic signed [SW-1:0]  dot_r;
  logic [AW-1:0]         rhs_r;

  function automatic logic signed [CB-1:0] cmp_of(logic [3*CB-1:0] v, logic [1:0] k);
    logic signed [CB-1:0] r;
    unique case (k)
      2'd0:    r = v[CB-1:0];
      2'd1:    r = v[2*CB-1:CB];
      default: r = v[3*CB-1:2*CB];
    endcase
    return r;
  endfunction

  logic [1:0] k1, k2;
  logic [2:0] ib;
  logic signed [LW-1:0] lc, lsel;
  logic signed [DW-1:0] dsel, asel, mul_b;
  logic signed [PW-1:0] prod;
  logic                 h_box;
  logic [1:0]           h_cmp;
  logic signed [CB-1:0] hval;
  logic [CB-1:0]        hmag;
  logic [SW-1:0]        dmag, lmag;
  logic [AW-1:0]        rprod, lhs_sh;

  always_comb begin
    k1 = (uop.comp == 2'd0) ? 2'd1 : (uop.comp == 2'd1) ? 2'd2 : 2'd0;
    k2 = (uop.comp == 2'd0) ? 2'd2 : (uop.comp == 2'd1) ? 2'd0 : 2'd1;
    ib = uop.sel_a + 3'd3;
    // cross: ref axis ax_i, test axis ax[ib]
    lc = LW'(cmp_of(ax[uop.ax_i], k1)) * LW'(cmp_of(ax[ib], k2))
       - LW'(cmp_of(ax[uop.ax_i], k2)) * LW'(cmp_of(ax[ib], k1));
    lsel = uop.use_ax ? LW'(cmp_of(ax[uop.ax_i], uop.comp)) : l_r[uop.comp];
    unique case (uop.comp)
      2'd0:    dsel = diff[DW-1:0];
      2'd1:    dsel = diff[2*DW-1:DW];
      default: dsel = diff[3*DW-1:2*DW];
    endcase
    // one multiplier serves diff . L and a_i . L
    asel = DW'(cmp_of(ax[uop.sel_a], uop.comp));
    mul_b = (uop.op == obb_pkg::OP_LHS) ? dsel : asel;
    prod = PW'(lsel) * PW'(mul_b);
    // |dot| * |h_i|, magnitudes taken as unsigned
    h_box = (uop.sel_a >= 3'd3);
    h_cmp = h_box ? 2'(uop.sel_a - 3'd3) : uop.sel_a[1:0];
    hval = cmp_of(hs[h_box], h_cmp);
    hmag = hval[CB-1] ? CB'(-hval) : CB'(hval);
    dmag = dot_r[SW-1] ? SW'(-dot_r) : SW'(dot_r);
    rprod = AW'(dmag) * AW'(hmag);
    lmag = lhs_r[SW-1] ? SW'(-lhs_r) : SW'(lhs_r);
    lhs_sh = AW'(lmag) << (CB - 2);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep <= 1'b0;
    end else begin
      unique case (uop.op)
        obb_pkg::OP_CROSS: l_r[uop.comp] <= lc;
        obb_pkg::OP_LHS:
          lhs_r <= (uop.first ? '0 : lhs_r) + SW'(prod);
        obb_pkg::OP_DOT:
          dot_r <= (uop.first ? '0 : dot_r) + SW'(prod);
        obb_pkg::OP_RHS:
          rhs_r <= (uop.first ? '0 : rhs_r) + rprod;
        obb_pkg::OP_CMP: sep <= lhs_sh > rhs_r;
        default: ;
      endcase
    end
  end
endmodule

@@ design/obb_overlap_separating_axis.sv @@
// Top level of the oriented-box separating-axis overlap test.
// Depends on obb_pkg and obb_dp (shared multiply-accumulate unit).
//
//  channel | ports                                  | direction
//  in      | in_valid/in_ready + nine field ports   | to block
//  out     | out_valid/out_ready, out_collide       | from block
//
// A load item stores the reference box. A test item sweeps 15 axes through the
// shared multipliers: 3 lhs, 18 dot, 6 rhs, 1 compare and 1 check step per
// axis, plus 3 cross steps on the 9 cross axes; the sweep stops early at the
// first separating axis. Excluded pairs are answered without a sweep, with no
// collision. Reset clears the reference box.
// in_ready is low while a test runs or a result waits in the output reg.
module obb_overlap_separating_axis #(
  parameter int unsigned COMPONENT_BITS = obb_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned BRANCH_BITS    = obb_pkg::BRANCH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [3*COMPONENT_BITS-1:0] in_origin,
  input  logic [3*COMPONENT_BITS-1:0] in_axis_x,
  input  logic [3*COMPONENT_BITS-1:0] in_axis_y,
  input  logic [3*COMPONENT_BITS-1:0] in_axis_z,
  input  logic [3*COMPONENT_BITS-1:0] in_half_sizes,
  input  logic [BRANCH_BITS-1:0]      in_branch_id,
  input  logic [BRANCH_BITS-1:0]      in_parent_id,
  input  logic                        in_skip_related,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_collide
);
  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned VW = 3*CB;

  typedef enum logic [2:0] {S_IDLE, S_CROSS, S_LHS, S_DOT, S_RHS, S_CMP, S_CHK} st_t;

  st_t st_r;
  logic [VW-1:0] ax_r [6];
  logic [VW-1:0] hs_r [2];
  logic [VW-1:0] org_r, torg_r;
  logic [BRANCH_BITS-1:0] br_r, pa_r;
  logic [3*CB+2:0] diff_r;
  logic [3:0] axis_r;   // 0..14
  logic [1:0] ri_r;     // reference axis of a cross axis
  logic [1:0] tj_r;     // test axis of a cross axis
  logic [2:0] ai_r;     // axis index in dot/rhs
  logic [1:0] k_r;
  logic out_valid_r, out_collide_r;
  logic sep;
  obb_pkg::uop_t uop;

  function automatic logic signed [CB:0] sx(logic [VW-1:0] v, int k);
    return (CB+1)'($signed(v[k*CB +: CB]));
  endfunction

  assign in_ready    = (st_r == S_IDLE) && !out_valid_r;
  assign out_valid   = out_valid_r;
  assign out_collide = out_collide_r;

  // Micro-op decode from sequencer state
  always_comb begin
    uop = '0;
    uop.comp  = k_r;
    uop.sel_a = ai_r;
    uop.first = (k_r == 2'd0) && (st_r != S_RHS || ai_r == 3'd0);
    uop.use_ax = axis_r < 4'd6;
    uop.ax_i  = (axis_r < 4'd6) ? 3'(axis_r) : {1'b0, ri_r};
    unique case (st_r)
      S_CROSS: begin
        uop.op = obb_pkg::OP_CROSS;
        uop.sel_a = {1'b0, tj_r};
      end
      S_LHS:   uop.op = obb_pkg::OP_LHS;
      S_DOT:   begin uop.op = obb_pkg::OP_DOT; uop.first = (k_r == 2'd0); end
      S_RHS:   begin uop.op = obb_pkg::OP_RHS; uop.first = (ai_r == 3'd0); end
      S_CMP:   uop.op = obb_pkg::OP_CMP;
      default: uop.op = obb_pkg::OP_NOP;
    endcase
  end

  // dot accumulator feeds rhs per axis: interleave DOT(3) then RHS(1) per ai
  obb_dp #(.CB(CB)) u_dp (
    .clk(clk), .rst_n(rst_n), .uop(uop), .ax(ax_r), .hs(hs_r),
    .diff(diff_r), .sep(sep)
  );

  // Sequencer and reference storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid_r <= 1'b0;
      out_collide_r <= 1'b0;
      org_r <= '0; ax_r[0] <= '0; ax_r[1] <= '0; ax_r[2] <= '0;
      hs_r[0] <= '0; br_r <= '0; pa_r <= '0;
      axis_r <= '0; ai_r <= '0; k_r <= '0; ri_r <= '0; tj_r <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid && in_ready) begin
          if (!in_action) begin
            org_r <= in_origin; ax_r[0] <= in_axis_x; ax_r[1] <= in_axis_y;
            ax_r[2] <= in_axis_z; hs_r[0] <= in_half_sizes;
            br_r <= in_branch_id; pa_r <= in_parent_id;
          end else if (in_skip_related && (in_branch_id == br_r ||
                       in_parent_id == pa_r || pa_r == in_branch_id ||
                       br_r == in_parent_id)) begin
            out_valid_r <= 1'b1; out_collide_r <= 1'b0;
          end else begin
            ax_r[3] <= in_axis_x; ax_r[4] <= in_axis_y; ax_r[5] <= in_axis_z;
            hs_r[1] <= in_half_sizes;
            diff_r <= {(CB+1)'(sx(in_origin,2) - sx(org_r,2)),
                       (CB+1)'(sx(in_origin,1) - sx(org_r,1)),
                       (CB+1)'(sx(in_origin,0) - sx(org_r,0))};
            axis_r <= '0; ai_r <= '0; k_r <= '0; ri_r <= '0; tj_r <= '0;
            st_r <= S_LHS;
          end
        end
        S_CROSS: begin
          k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          if (k_r == 2'd2) st_r <= S_LHS;
        end
        S_LHS: begin
          k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          if (k_r == 2'd2) begin st_r <= S_DOT; ai_r <= '0; end
        end
        S_DOT: begin
          k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          if (k_r == 2'd2) st_r <= S_RHS;
        end
        S_RHS: begin
          if (ai_r == 3'd5) st_r <= S_CMP;
          else begin ai_r <= ai_r + 3'd1; st_r <= S_DOT; end
        end
        S_CMP: st_r <= S_CHK;
        S_CHK: begin
          k_r <= '0; ai_r <= '0;
          if (sep || axis_r == 4'd14) begin
            out_valid_r <= 1'b1; out_collide_r <= !sep;
            st_r <= S_IDLE;
          end else begin
            axis_r <= axis_r + 4'd1;
            // step the cross axis pair: test axis inner, reference axis outer
            if (axis_r >= 4'd6) begin
              if (tj_r == 2'd2) begin
                tj_r <= '0;
                ri_r <= ri_r + 2'd1;
              end else begin
                tj_r <= tj_r + 2'd1;
              end
            end
            st_r <= (axis_r + 4'd1 >= 4'd6) ? S_CROSS : S_LHS;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
